// ===== hw/rtl/rsa_crt_modexp_defines.svh =====
// ----------------------------------------------------------------------------
// rsa_crt_modexp_defines
// Assertion macros shared by the RSA CRT block.
// ----------------------------------------------------------------------------
`ifndef RSA_CRT_MODEXP_DEFINES_SVH
`define RSA_CRT_MODEXP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled during reset.
`define RCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hw/rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, register indexes and the multiplier command struct.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int PRIME_BITS = 15;
    localparam int W_WIDE     = 30;
    localparam int CNT_W      = $clog2(W_WIDE + 1);
    localparam int ADDR_W     = 5;

    localparam logic [2:0] REG_PRIME_P  = 3'd0;
    localparam logic [2:0] REG_PRIME_Q  = 3'd1;
    localparam logic [2:0] REG_MODULUS  = 3'd2;
    localparam logic [2:0] REG_PUB_EXP  = 3'd3;
    localparam logic [2:0] REG_PRIV_EXP = 3'd4;
    localparam logic [2:0] REG_COEF_P   = 3'd5;
    localparam logic [2:0] REG_COEF_Q   = 3'd6;

    // go: launch one operation; mul: a*b mod m, else b mod m;
    // narrow: b holds PRIME_BITS significant bits.
    typedef struct packed {
        logic go;
        logic mul;
        logic narrow;
    } t_mm_cmd;

endpackage

// ===== hw/rtl/rcm_mulmod.sv =====
// ----------------------------------------------------------------------------
// rcm_mulmod
// Bit-serial modular multiplier and reducer, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`include "rsa_crt_modexp_defines.svh"

module rcm_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcm_pkg::t_mm_cmd              i_cmd,
    input  logic [rcm_pkg::W_WIDE-1:0]    i_a,
    input  logic [rcm_pkg::W_WIDE-1:0]    i_b,
    input  logic [rcm_pkg::W_WIDE-1:0]    i_m,
    output logic                          o_done,
    output logic [rcm_pkg::W_WIDE-1:0]    o_res
);
    import rcm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_mul;
    logic [CNT_W-1:0]  r_cnt;
    logic [W_WIDE-1:0] r_a;
    logic [W_WIDE-1:0] r_b;
    logic [W_WIDE-1:0] r_m;
    logic [W_WIDE-1:0] r_r;

    logic [W_WIDE:0]   w_dbl;
    logic [W_WIDE:0]   w_s0;
    logic [W_WIDE-1:0] w_add;
    logic [W_WIDE:0]   w_sum;
    logic [W_WIDE:0]   w_s1;

    // Double, fold once, add the digit, fold once.
    always_comb begin
        w_dbl = {r_r, 1'b0};
        w_s0  = (w_dbl >= {1'b0, r_m}) ? (w_dbl - {1'b0, r_m}) : w_dbl;
        if (r_mul) begin
            w_add = r_b[W_WIDE-1] ? r_a : '0;
        end else begin
            w_add = {{(W_WIDE-1){1'b0}}, r_b[W_WIDE-1]};
        end
        w_sum = w_s0 + {1'b0, w_add};
        w_s1  = (w_sum >= {1'b0, r_m}) ? (w_sum - {1'b0, r_m}) : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.narrow ? CNT_W'(PRIME_BITS) : CNT_W'(W_WIDE);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_mul <= i_cmd.mul;
            r_a   <= i_a;
            r_m   <= i_m;
            r_r   <= '0;
            r_b   <= i_cmd.narrow ? (i_b << (W_WIDE - PRIME_BITS)) : i_b;
        end else if (r_busy) begin
            r_r <= w_s1[W_WIDE-1:0];
            r_b <= r_b << 1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;

    `RCM_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_cmd.go, !r_busy)
    `RCM_ASSERT_NXT(a_done_ends, i_clk, i_rst_n, r_done, !r_busy)
    `RCM_ASSERT_IMP(a_res_reduced, i_clk, i_rst_n, r_done && (r_m != '0), r_r < r_m)

endmodule

// ===== hw/rtl/rsa_crt_modexp.sv =====
// ----------------------------------------------------------------------------
// rsa_crt_modexp
// RSA modular exponentiation of one value through the Chinese remainder theorem.
// ----------------------------------------------------------------------------
// Usage:
//   Load keys through the APB port: prime_p at 0x00, prime_q 0x04, modulus
//   0x08, public exponent 0x0C, private exponent 0x10, coef_p 0x14, coef_q
//   0x18. pready is always high; reads return the stored value.
//   Issue a transfer by raising start with opcode (0 encrypt with e, 1
//   decrypt with d) and value while busy is low. The result appears on
//   o_result, marked by o_valid high for one cycle; the receiver cannot stall
//   it, so latch it on the strobe.
//   Work: all reductions and multiplies run on one shared bit-serial
//   multiplier; the final sum uses its own adder. There are four 30-bit
//   reductions, up to 60 15-bit multiplies for the two exponentiations,
//   and ten 30-bit recombination steps; the number of multiplies is set
//   by the bits of the reduced exponents (none for a zero reduced exponent
//   or a zero residue). Degenerate keys (a prime below 2 or zero modulus)
//   return 0 in the cycle after the transfer.
//   One item at a time: busy stays high until the result strobe.
//   Reset: keys return to p = q = 3, others 0; the sequencer goes idle.
// ----------------------------------------------------------------------------
`include "rsa_crt_modexp_defines.svh"

module rsa_crt_modexp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcm_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic [rcm_pkg::W_WIDE-1:0]         i_value,
    output logic                               o_valid,
    output logic [rcm_pkg::W_WIDE-1:0]         o_result
);
    import rcm_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_RED_VP   = 14'b00000000000010,
        ST_RED_VQ   = 14'b00000000000100,
        ST_RED_EP   = 14'b00000000001000,
        ST_RED_EQ   = 14'b00000000010000,
        ST_POW_INIT = 14'b00000000100000,
        ST_POW_MUL  = 14'b00000001000000,
        ST_POW_SQR  = 14'b00000010000000,
        ST_REC_PRM  = 14'b00000100000000,
        ST_REC_COEF = 14'b00001000000000,
        ST_REC_MUL1 = 14'b00010000000000,
        ST_REC_X    = 14'b00100000000000,
        ST_REC_MUL2 = 14'b01000000000000,
        ST_SUM      = 14'b10000000000000
    } t_state;

    // Key registers
    logic [PRIME_BITS-1:0] r_p;
    logic [PRIME_BITS-1:0] r_q;
    logic [W_WIDE-1:0]     r_n;
    logic [W_WIDE-1:0]     r_pub;
    logic [W_WIDE-1:0]     r_priv;
    logic [PRIME_BITS-1:0] r_cp;
    logic [PRIME_BITS-1:0] r_cq;

    // Sequencer and datapath
    t_state                r_state;
    logic                  r_run;
    logic                  r_side;
    logic                  r_valid;
    logic [W_WIDE-1:0]     r_result;
    logic [W_WIDE-1:0]     r_val;
    logic [W_WIDE-1:0]     r_exp;
    logic [PRIME_BITS-1:0] r_rp;
    logic [PRIME_BITS-1:0] r_rq;
    logic [PRIME_BITS-1:0] r_ep;
    logic [PRIME_BITS-1:0] r_eq;
    logic [PRIME_BITS-1:0] r_acc;
    logic [PRIME_BITS-1:0] r_sq;
    logic [PRIME_BITS-1:0] r_e;
    logic [PRIME_BITS-1:0] r_xp;
    logic [PRIME_BITS-1:0] r_xq;
    logic [W_WIDE-1:0]     r_t;
    logic [W_WIDE-1:0]     r_u;
    logic [W_WIDE-1:0]     r_t1;

    t_mm_cmd               w_cmd;
    logic [W_WIDE-1:0]     w_a;
    logic [W_WIDE-1:0]     w_b;
    logic [W_WIDE-1:0]     w_m;
    logic                  w_done;
    logic [W_WIDE-1:0]     w_res;
    logic [PRIME_BITS-1:0] w_base;
    logic [PRIME_BITS-1:0] w_pmod;
    logic [W_WIDE:0]       w_sum;
    logic [W_WIDE:0]       w_fold;
    logic                  w_accept;
    logic                  w_degen;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_accept = start && !busy;
    assign w_degen  = (r_p < PRIME_BITS'(2)) || (r_q < PRIME_BITS'(2)) || (r_n == '0);
    assign w_base   = r_side ? r_rq : r_rp;
    assign w_pmod   = r_side ? r_q : r_p;
    assign w_sum    = {1'b0, r_t1} + {1'b0, r_t};
    assign w_fold   = (w_sum >= {1'b0, r_n}) ? (w_sum - {1'b0, r_n}) : w_sum;

    // Configuration writes; fields are truncated to their register widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p    <= PRIME_BITS'(3);
            r_q    <= PRIME_BITS'(3);
            r_n    <= '0;
            r_pub  <= '0;
            r_priv <= '0;
            r_cp   <= '0;
            r_cq   <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_PRIME_P:  r_p    <= pwdata[PRIME_BITS-1:0];
                REG_PRIME_Q:  r_q    <= pwdata[PRIME_BITS-1:0];
                REG_MODULUS:  r_n    <= pwdata[W_WIDE-1:0];
                REG_PUB_EXP:  r_pub  <= pwdata[W_WIDE-1:0];
                REG_PRIV_EXP: r_priv <= pwdata[W_WIDE-1:0];
                REG_COEF_P:   r_cp   <= pwdata[PRIME_BITS-1:0];
                REG_COEF_Q:   r_cq   <= pwdata[PRIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PRIME_P:  prdata = 32'(r_p);
            REG_PRIME_Q:  prdata = 32'(r_q);
            REG_MODULUS:  prdata = 32'(r_n);
            REG_PUB_EXP:  prdata = 32'(r_pub);
            REG_PRIV_EXP: prdata = 32'(r_priv);
            REG_COEF_P:   prdata = 32'(r_cp);
            REG_COEF_Q:   prdata = 32'(r_cq);
            default:      prdata = '0;
        endcase
    end

    // Shared multiplier inputs; go fires once on entry, bar POW_MUL at even r_e.
    always_comb begin
        w_cmd = '0;
        w_a   = '0;
        w_b   = '0;
        w_m   = '0;
        unique case (r_state)
            ST_RED_VP: begin
                w_cmd.go = !r_run;
                w_b      = r_val;
                w_m      = W_WIDE'(r_p);
            end
            ST_RED_VQ: begin
                w_cmd.go = !r_run;
                w_b      = r_val;
                w_m      = W_WIDE'(r_q);
            end
            ST_RED_EP: begin
                w_cmd.go = !r_run;
                w_b      = r_exp;
                w_m      = W_WIDE'(r_p - 1'b1);
            end
            ST_RED_EQ: begin
                w_cmd.go = !r_run;
                w_b      = r_exp;
                w_m      = W_WIDE'(r_q - 1'b1);
            end
            ST_POW_MUL: begin
                w_cmd.go     = !r_run && (r_e != '0) && r_e[0];
                w_cmd.mul    = 1'b1;
                w_cmd.narrow = 1'b1;
                w_a          = W_WIDE'(r_acc);
                w_b          = W_WIDE'(r_sq);
                w_m          = W_WIDE'(w_pmod);
            end
            ST_POW_SQR: begin
                w_cmd.go     = !r_run;
                w_cmd.mul    = 1'b1;
                w_cmd.narrow = 1'b1;
                w_a          = W_WIDE'(r_sq);
                w_b          = W_WIDE'(r_sq);
                w_m          = W_WIDE'(w_pmod);
            end
            ST_REC_PRM: begin
                w_cmd.go = !r_run;
                w_b      = r_side ? W_WIDE'(r_p) : W_WIDE'(r_q);
                w_m      = r_n;
            end
            ST_REC_COEF: begin
                w_cmd.go = !r_run;
                w_b      = r_side ? W_WIDE'(r_cq) : W_WIDE'(r_cp);
                w_m      = r_n;
            end
            ST_REC_X: begin
                w_cmd.go = !r_run;
                w_b      = r_side ? W_WIDE'(r_xq) : W_WIDE'(r_xp);
                w_m      = r_n;
            end
            ST_REC_MUL1, ST_REC_MUL2: begin
                w_cmd.go  = !r_run;
                w_cmd.mul = 1'b1;
                w_a       = r_t;
                w_b       = r_u;
                w_m       = r_n;
            end
            default: ;
        endcase
    end

    rcm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (w_m),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_run   <= 1'b0;
            r_side  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (w_cmd.go) begin
                r_run <= 1'b1;
            end
            if (w_done) begin
                r_run <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_val  <= i_value;
                        r_exp  <= i_opcode ? r_priv : r_pub;
                        r_side <= 1'b0;
                        if (w_degen) begin
                            // Bad keys: answer zero at once.
                            r_result <= '0;
                            r_valid  <= 1'b1;
                        end else begin
                            r_state <= ST_RED_VP;
                        end
                    end
                end
                ST_RED_VP: if (w_done) begin
                    r_rp    <= w_res[PRIME_BITS-1:0];
                    r_state <= ST_RED_VQ;
                end
                ST_RED_VQ: if (w_done) begin
                    r_rq    <= w_res[PRIME_BITS-1:0];
                    r_state <= ST_RED_EP;
                end
                ST_RED_EP: if (w_done) begin
                    r_ep    <= w_res[PRIME_BITS-1:0];
                    r_state <= ST_RED_EQ;
                end
                ST_RED_EQ: if (w_done) begin
                    r_eq    <= w_res[PRIME_BITS-1:0];
                    r_state <= ST_POW_INIT;
                end
                ST_POW_INIT: begin
                    r_acc <= PRIME_BITS'(1);
                    r_sq  <= w_base;
                    r_e   <= r_side ? r_eq : r_ep;
                    if (w_base == '0) begin
                        // Zero residue stays zero for any exponent.
                        if (r_side) begin
                            r_xq    <= '0;
                            r_side  <= 1'b0;
                            r_state <= ST_REC_PRM;
                        end else begin
                            r_xp    <= '0;
                            r_side  <= 1'b1;
                        end
                    end else begin
                        r_state <= ST_POW_MUL;
                    end
                end
                ST_POW_MUL: begin
                    if (r_e == '0) begin
                        if (r_side) begin
                            r_xq    <= r_acc;
                            r_side  <= 1'b0;
                            r_state <= ST_REC_PRM;
                        end else begin
                            r_xp    <= r_acc;
                            r_side  <= 1'b1;
                            r_state <= ST_POW_INIT;
                        end
                    end else if (!r_e[0]) begin
                        r_state <= ST_POW_SQR;
                    end else if (w_done) begin
                        r_acc   <= w_res[PRIME_BITS-1:0];
                        r_state <= ST_POW_SQR;
                    end
                end
                ST_POW_SQR: if (w_done) begin
                    r_sq    <= w_res[PRIME_BITS-1:0];
                    r_e     <= r_e >> 1;
                    r_state <= ST_POW_MUL;
                end
                ST_REC_PRM: if (w_done) begin
                    r_t     <= w_res;
                    r_state <= ST_REC_COEF;
                end
                ST_REC_COEF: if (w_done) begin
                    r_u     <= w_res;
                    r_state <= ST_REC_MUL1;
                end
                ST_REC_MUL1: if (w_done) begin
                    r_t     <= w_res;
                    r_state <= ST_REC_X;
                end
                ST_REC_X: if (w_done) begin
                    r_u     <= w_res;
                    r_state <= ST_REC_MUL2;
                end
                ST_REC_MUL2: if (w_done) begin
                    r_t <= w_res;
                    if (r_side) begin
                        r_state <= ST_SUM;
                    end else begin
                        // Hold the p-side term, repeat for q.
                        r_t1    <= w_res;
                        r_side  <= 1'b1;
                        r_state <= ST_REC_PRM;
                    end
                end
                ST_SUM: begin
                    r_result <= w_fold[W_WIDE-1:0];
                    r_valid  <= 1'b1;
                    r_side   <= 1'b0;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `RCM_ASSERT_IMP(a_busy_ends_in_strobe, i_clk, i_rst_n, $fell(busy), o_valid)
    `RCM_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, w_accept, busy || o_valid)
    `RCM_ASSERT_IMP(a_run_only_busy, i_clk, i_rst_n, r_run, busy)

endmodule
